FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Used by i2cm_front, i2cm_back and i2c_master_bit_engine_top; no dependencies.
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    localparam logic [3:0] POLL_PHASE = 4'd2;

    localparam int TPU_W = 10;
    localparam int TMO_W = 8;
    localparam int CFG_W = 10;
    localparam int CFG_IDX_W = 1;
    localparam int DLY_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'b1;

    localparam logic [TPU_W-1:0] TPU_RESET = 10'd1;
    localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       send_ack;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_is_output;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } out_word_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       send_ack;
        logic       sda_in;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

FILE: rtl/i2cm_front.sv
// Front end: accepts input words, decodes the op into a command, queues them.
// Depends on i2cm_pkg.
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  in_word_t cmd_word,
    output q_head_t  head,
    input  logic     pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    q_entry_t        entry;

    always_comb
    begin
        entry.data     = cmd_word.data;
        entry.send_ack = cmd_word.send_ack;
        entry.sda_in   = cmd_word.sda_in;
        case (cmd_word.op)
            CMD_START: entry.cmd = CMD_START;
            CMD_STOP:  entry.cmd = CMD_STOP;
            CMD_WRITE: entry.cmd = CMD_WRITE;
            CMD_WAIT:  entry.cmd = CMD_WAIT;
            CMD_READ:  entry.cmd = CMD_READ;
            default:   entry.cmd = CMD_NONE;
        endcase
    end

    assign cmd_stall = (count_reg == CW'(DEPTH));
    assign push      = cmd_valid && !cmd_stall;

    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

FILE: rtl/i2cm_back.sv
// Back end: bus phase sequencer, config registers and result register.
// Depends on i2cm_pkg; takes words from i2cm_front.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_head_t              head,
    output logic                 pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output out_word_t            rsp_word
);

    logic [TPU_W-1:0] tpu_reg;
    logic [TMO_W-1:0] tmo_reg;

    cmd_t             cmd_reg, cmd_next;
    logic [3:0]       phase_reg, phase_next;
    logic [3:0]       bit_reg, bit_next;
    logic [DLY_W-1:0] dly_reg, dly_next;
    logic [7:0]       poll_reg, poll_next;
    logic [7:0]       shift_reg, shift_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             dir_reg, dir_next;
    logic             nack_reg, nack_next;
    logic             ack_lat_reg, ack_lat_next;
    logic [7:0]       rx_reg, rx_next;
    logic             done_next;

    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg, out_word_next;

    logic             run;
    logic [3:0]       run_ph;
    logic [3:0]       nxt;
    logic [2:0]       us;
    logic             fin;
    logic             poll;
    logic [TPU_W-1:0] tick;
    logic [DLY_W-1:0] prod;
    q_entry_t         e;

    assign e   = head.entry;
    assign pop = head.valid && (!out_valid_reg || !rsp_stall);
    assign tick = (tpu_reg == '0) ? TPU_W'(1) : tpu_reg;

    always_comb
    begin
        cmd_next     = cmd_reg;
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        dly_next     = dly_reg;
        poll_next    = poll_reg;
        shift_next   = shift_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        dir_next     = dir_reg;
        nack_next    = nack_reg;
        ack_lat_next = ack_lat_reg;
        rx_next      = rx_reg;
        done_next    = 1'b0;
        run          = 1'b0;
        run_ph       = 4'd0;
        nxt          = 4'd0;
        us           = 3'd0;
        fin          = 1'b0;
        poll         = 1'b0;
        prod         = '0;

        if (cmd_reg == CMD_NONE)
        begin
            if (e.cmd != CMD_NONE)
            begin
                cmd_next = e.cmd;
                if (e.cmd == CMD_WRITE)
                begin
                    shift_next = e.data;
                end
                if (e.cmd == CMD_READ)
                begin
                    ack_lat_next = e.send_ack;
                end
                run = 1'b1;
            end
        end
        else if (cmd_reg == CMD_WAIT && phase_reg == POLL_PHASE)
        begin
            if (!e.sda_in)
            begin
                scl_next  = 1'b0;
                nack_next = 1'b0;
                run       = 1'b1;
                run_ph    = 4'd5;
            end
            else if (poll_reg >= tmo_reg)
            begin
                nack_next = 1'b1;
                run       = 1'b1;
                run_ph    = 4'd3;
            end
            else
            begin
                poll_next = poll_reg + 1'b1;
            end
        end
        else
        begin
            if (dly_reg != '0)
            begin
                dly_next = dly_reg - 1'b1;
            end
            if (dly_next == '0)
            begin
                run    = 1'b1;
                run_ph = phase_reg;
            end
        end

        if (run)
        begin
            nxt = run_ph + 1'b1;
            case (cmd_next)
                CMD_START:
                begin
                    case (run_ph)
                        4'd0:
                        begin
                            dir_next = 1'b1;
                            sda_next = 1'b1;
                            scl_next = 1'b1;
                            us       = 3'd4;
                        end
                        4'd1:
                        begin
                            sda_next = 1'b0;
                            us       = 3'd4;
                        end
                        default:
                        begin
                            scl_next = 1'b0;
                            fin      = 1'b1;
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    case (run_ph)
                        4'd0:
                        begin
                            scl_next = 1'b0;
                            dir_next = 1'b1;
                            sda_next = 1'b0;
                            us       = 3'd4;
                        end
                        4'd1:
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            us       = 3'd4;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    case (run_ph)
                        4'd0:
                        begin
                            scl_next = 1'b0;
                            dir_next = 1'b1;
                            bit_next = 4'd0;
                            sda_next = shift_next[7];
                            us       = 3'd2;
                            nxt      = 4'd2;
                        end
                        4'd1:
                        begin
                            sda_next = shift_next[3'd7 - bit_next[2:0]];
                            us       = 3'd2;
                        end
                        4'd2:
                        begin
                            scl_next = 1'b1;
                            us       = 3'd2;
                        end
                        4'd3:
                        begin
                            scl_next = 1'b0;
                            us       = 3'd2;
                            bit_next = bit_reg + 1'b1;
                            nxt      = (bit_next < 4'd8) ? 4'd1 : 4'd4;
                        end
                        default:
                        begin
                            sda_next = 1'b1;
                            fin      = 1'b1;
                        end
                    endcase
                end
                CMD_WAIT:
                begin
                    case (run_ph)
                        4'd0:
                        begin
                            scl_next  = 1'b0;
                            dir_next  = 1'b1;
                            sda_next  = 1'b1;
                            us        = 3'd1;
                            poll_next = 8'd0;
                        end
                        4'd1:
                        begin
                            dir_next = 1'b0;
                            scl_next = 1'b1;
                            us       = 3'd1;
                        end
                        4'd2:
                        begin
                            poll = 1'b1;
                        end
                        4'd3:
                        begin
                            scl_next = 1'b0;
                            dir_next = 1'b1;
                            sda_next = 1'b0;
                            us       = 3'd4;
                        end
                        4'd4:
                        begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            us       = 3'd4;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    case (run_ph)
                        4'd0:
                        begin
                            scl_next   = 1'b0;
                            dir_next   = 1'b0;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            us         = 3'd2;
                            nxt        = 4'd2;
                        end
                        4'd1:
                        begin
                            scl_next = 1'b0;
                            us       = 3'd2;
                        end
                        4'd2:
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], e.sda_in};
                            bit_next   = bit_reg + 1'b1;
                            us         = 3'd1;
                            nxt        = (bit_next < 4'd8) ? 4'd1 : 4'd4;
                        end
                        4'd4:
                        begin
                            scl_next = 1'b0;
                            dir_next = 1'b1;
                            sda_next = !ack_lat_next;
                            us       = 3'd2;
                        end
                        4'd5:
                        begin
                            scl_next = 1'b1;
                            us       = 3'd2;
                        end
                        default:
                        begin
                            scl_next = 1'b0;
                            rx_next  = shift_next;
                            fin      = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase

            case (us)
                3'd4:    prod = {tick, 2'b00};
                3'd2:    prod = {1'b0, tick, 1'b0};
                default: prod = {2'b00, tick};
            endcase

            if (fin)
            begin
                cmd_next   = CMD_NONE;
                phase_next = 4'd0;
                dly_next   = '0;
                done_next  = 1'b1;
            end
            else if (poll)
            begin
                phase_next = run_ph;
            end
            else
            begin
                phase_next = nxt;
                dly_next   = (prod == '0) ? DLY_W'(1) : prod;
            end
        end
    end

    always_comb
    begin
        out_word_next.scl           = scl_next;
        out_word_next.sda_out       = sda_next;
        out_word_next.sda_is_output = dir_next;
        out_word_next.busy_res      = (cmd_next != CMD_NONE);
        out_word_next.done_res      = done_next;
        out_word_next.rx_byte       = rx_next;
        out_word_next.nack_seen     = nack_next;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= TPU_RESET;
            tmo_reg <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_US: tpu_reg <= cfg_wdata[TPU_W-1:0];
                REG_ACK_TIMEOUT:  tmo_reg <= cfg_wdata[TMO_W-1:0];
                default:          tpu_reg <= tpu_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_NONE;
            phase_reg     <= 4'd0;
            bit_reg       <= 4'd0;
            dly_reg       <= '0;
            poll_reg      <= 8'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            dir_reg       <= 1'b1;
            nack_reg      <= 1'b0;
            ack_lat_reg   <= 1'b0;
            rx_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                cmd_reg     <= cmd_next;
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                dly_reg     <= dly_next;
                poll_reg    <= poll_next;
                shift_reg   <= shift_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                dir_reg     <= dir_next;
                nack_reg    <= nack_next;
                ack_lat_reg <= ack_lat_next;
                rx_reg      <= rx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

`ifndef SYNTH
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_NONE |-> dly_reg == '0)
        else $error("delay pending while idle");
    a_delay_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg != CMD_NONE && !(cmd_reg == CMD_WAIT && phase_reg == POLL_PHASE))
        |-> dly_reg != '0)
        else $error("active phase without delay");
    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit index out of range");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(out_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine: one word per bus tick in, one line-state word out.
// Channels: cmd_valid/cmd_stall/cmd_word in, rsp_valid/rsp_stall/rsp_word out.
// Each accepted word (op, data, send_ack, sampled sda_in) is one tick of the
// bus sequencer and yields exactly one result word with the SCL/SDA drive
// levels, busy, done pulse, last received byte and nack flag after that tick.
// A command op is taken only while the engine is idle; otherwise it is ignored.
// Each word is stored in the input queue; once taken, its result is registered.
// Throughput: one word per cycle while rsp_stall is low; the phase sequencer
// evaluates one tick per word taken, and the two-entry input queue keeps input
// and output stalls apart. With a result pending and rsp_stall high, the result
// register holds, the sequencer pauses and the queue fills, then cmd_stall rises.
// Config: cfg_we writes cfg_wdata into ticks_per_us (index 0) or ack_timeout
// (index 1); write only while idle.
// Reset (rst_n low, async): engine idle, SCL high, SDA driven high, queue
// empty, ticks_per_us 1, ack_timeout 250.
module i2c_master_bit_engine_top
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  in_word_t             cmd_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output out_word_t            rsp_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    q_head_t head;
    logic    pop;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .head      (head),
        .pop       (pop)
    );

    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
